// ===== hw/rtl/rpud_pkg.sv =====
package rpud_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int DIR_WIDTH_DEF   = 16;
    localparam int ROOM_W          = 16;
    localparam int CFG_IDX_W       = 3;

    // the largest normalized magnitude sits in [2^30, 2^31)
    localparam int NORM_W   = 31;
    localparam int SUM_W    = 64;
    localparam int ROOT_W   = 32;
    localparam int SQ_REM_W = 35;
    localparam int DIV_REM_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ROOM_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOM_DEPTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOM_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LISTENER_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LISTENER_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LISTENER_Z  = 3'd5;

    typedef logic [2:0] t_status;

    localparam t_status ST_OK       = 3'd0;
    localparam t_status ST_NOT_CART = 3'd1;
    localparam t_status ST_SCREEN   = 3'd2;
    localparam t_status ST_INFINITE = 3'd3;
    localparam t_status ST_POLICY   = 3'd4;
    localparam t_status ST_ZERO     = 3'd5;

    typedef struct packed {
        logic    valid;
        t_status status;
        logic [2:0] neg;
    } t_ctrl;

endpackage

// ===== hw/rtl/rpud_front.sv =====
module rpud_front
    import rpud_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int CFG_W       = 16,
    parameter int CMP_W       = COORD_WIDTH + 18
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [CFG_W-1:0]              i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_pos_x,
    input  logic signed [COORD_WIDTH-1:0] i_pos_y,
    input  logic signed [COORD_WIDTH-1:0] i_pos_z,
    input  logic [1:0]                    i_coordinate_kind,
    input  logic                          i_cartesian_known,
    input  logic                          i_cartesian_flag,
    input  logic                          i_screen_anchored,
    input  logic                          i_distance_infinite,
    output logic                          o_valid,
    input  logic                          i_full,
    output t_status                       o_status,
    output logic signed [CMP_W-1:0]       o_front,
    output logic signed [CMP_W-1:0]       o_right,
    output logic signed [CMP_W-1:0]       o_up
);

    localparam int CW = COORD_WIDTH;
    localparam logic signed [CW-1:0] LIS_HALF = {3'b001, {(CW-3){1'b0}}};
    localparam logic signed [CW-1:0] POS_ONE  = {2'b01, {(CW-2){1'b0}}};
    localparam logic signed [CW-1:0] NEG_ONE  = {2'b11, {(CW-2){1'b0}}};

    logic [ROOM_W-1:0]      r_room_width, r_room_depth, r_room_height;
    logic signed [CW-1:0]   r_lis_x, r_lis_y, r_lis_z;
    logic                   r_valid;
    t_status                r_status, n_status;
    logic signed [CMP_W-1:0] r_front, r_right, r_up, n_front, n_right, n_up;
    logic signed [CW:0]     dx, dy, dz;
    logic                   load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_room_width  <= ROOM_W'(1280);
            r_room_depth  <= ROOM_W'(1280);
            r_room_height <= ROOM_W'(768);
            r_lis_x       <= LIS_HALF;
            r_lis_y       <= LIS_HALF;
            r_lis_z       <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROOM_WIDTH:  r_room_width  <= i_cfg_data[ROOM_W-1:0];
                CFG_ROOM_DEPTH:  r_room_depth  <= i_cfg_data[ROOM_W-1:0];
                CFG_ROOM_HEIGHT: r_room_height <= i_cfg_data[ROOM_W-1:0];
                CFG_LISTENER_X:  r_lis_x       <= i_cfg_data[CW-1:0];
                CFG_LISTENER_Y:  r_lis_y       <= i_cfg_data[CW-1:0];
                CFG_LISTENER_Z:  r_lis_z       <= i_cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        priority if (i_coordinate_kind != 2'd1 || !i_cartesian_known || !i_cartesian_flag)
            n_status = ST_NOT_CART;
        else if (i_screen_anchored)
            n_status = ST_SCREEN;
        else if (i_distance_infinite)
            n_status = ST_INFINITE;
        else if (r_room_width == '0 || r_room_depth == '0 || r_room_height == '0 ||
                 r_lis_x < 0 || r_lis_x > POS_ONE || r_lis_y < 0 || r_lis_y > POS_ONE ||
                 r_lis_z < NEG_ONE || r_lis_z > POS_ONE)
            n_status = ST_POLICY;
        else
            n_status = ST_OK;
    end

    assign dy = $signed({r_lis_y[CW-1], r_lis_y}) - $signed({i_pos_y[CW-1], i_pos_y});
    assign dx = $signed({i_pos_x[CW-1], i_pos_x}) - $signed({r_lis_x[CW-1], r_lis_x});
    assign dz = $signed({i_pos_z[CW-1], i_pos_z}) - $signed({r_lis_z[CW-1], r_lis_z});

    always_comb begin
        n_front = (CMP_W'(dy) * CMP_W'($signed({1'b0, r_room_depth}))) <<< 1;
        n_right = (CMP_W'(dx) * CMP_W'($signed({1'b0, r_room_width}))) <<< 1;
        n_up    = CMP_W'(dz) * CMP_W'($signed({1'b0, r_room_height}));
    end

    assign o_stall = r_valid && i_full;
    assign load    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (!i_full) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_status <= n_status;
            r_front  <= n_front;
            r_right  <= n_right;
            r_up     <= n_up;
        end
    end

    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_front  = r_front;
    assign o_right  = r_right;
    assign o_up     = r_up;

endmodule

// ===== hw/rtl/rpud_fifo.sv =====
module rpud_fifo
    import rpud_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr, r_rd;
    logic [1:0]       r_cnt;
    logic             push, pop;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign push    = i_push && !o_full;
    assign pop     = i_pop && o_valid;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wr <= !r_wr;
            if (pop)  r_rd <= !r_rd;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

// ===== hw/rtl/rpud_sqrt.sv =====
module rpud_sqrt
    import rpud_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [SUM_W-1:0]  i_sum,
    output logic [ROOT_W-1:0] o_root
);

    logic [SUM_W-1:0]    r_n    [ROOT_W];
    logic [SQ_REM_W-1:0] r_rem  [ROOT_W];
    logic [ROOT_W-1:0]   r_root [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic [SUM_W-1:0]    p_n;
        logic [SQ_REM_W-1:0] p_rem, s_rem, trial;
        logic [ROOT_W-1:0]   p_root;
        logic                ge;

        if (k == 0) begin : g_first
            assign p_n    = i_sum;
            assign p_rem  = '0;
            assign p_root = '0;
        end else begin : g_next
            assign p_n    = r_n[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
        end

        // bring down the next bit pair and try root*4+1
        assign s_rem = {p_rem[SQ_REM_W-3:0], p_n[SUM_W-1:SUM_W-2]};
        assign trial = SQ_REM_W'({p_root, 2'b01});
        assign ge    = s_rem >= trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[k]    <= p_n << 2;
                r_rem[k]  <= ge ? s_rem - trial : s_rem;
                r_root[k] <= {p_root[ROOT_W-2:0], ge};
            end
        end
    end

    assign o_root = r_root[ROOT_W-1];

endmodule

// ===== hw/rtl/rpud_div.sv =====
module rpud_div
    import rpud_pkg::*;
#(
    parameter int DIR_WIDTH = DIR_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [NORM_W-1:0]    i_mag,
    input  logic [ROOT_W-1:0]    i_root,
    output logic [DIR_WIDTH-1:0] o_quot
);

    localparam int Q   = DIR_WIDTH;
    localparam int DVW = NORM_W + DIR_WIDTH;

    logic [DVW-1:0]       dividend;
    logic [DIV_REM_W-1:0] r_rem  [Q+1];
    logic [Q-1:0]         r_low  [Q+1];
    logic [Q-1:0]         r_quot [Q+1];
    logic [ROOT_W-1:0]    r_den  [Q+1];

    // rounded dividend: mag * 2^(DIR_WIDTH-1) + root/2
    assign dividend = DVW'({i_mag, {(DIR_WIDTH-1){1'b0}}}) + DVW'(i_root[ROOT_W-1:1]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= DIV_REM_W'(dividend[DVW-1:Q]);
            r_low[0]  <= dividend[Q-1:0];
            r_quot[0] <= '0;
            r_den[0]  <= i_root;
        end
    end

    for (genvar k = 1; k <= Q; k++) begin : g_step
        logic [DIV_REM_W:0] s_rem;
        logic               ge;

        assign s_rem = {r_rem[k-1], r_low[k-1][Q-1]};
        assign ge    = s_rem >= {1'b0, r_den[k-1]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? DIV_REM_W'(s_rem - {1'b0, r_den[k-1]})
                                : DIV_REM_W'(s_rem);
                r_low[k]  <= r_low[k-1] << 1;
                r_quot[k] <= {r_quot[k-1][Q-2:0], ge};
                r_den[k]  <= r_den[k-1];
            end
        end
    end

    assign o_quot = r_quot[Q];

endmodule

// ===== hw/rtl/rpud_back.sv =====
module rpud_back
    import rpud_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int DIR_WIDTH   = DIR_WIDTH_DEF,
    parameter int CMP_W       = COORD_WIDTH + 18
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_pop,
    input  t_status                     i_status,
    input  logic signed [CMP_W-1:0]     i_front,
    input  logic signed [CMP_W-1:0]     i_right,
    input  logic signed [CMP_W-1:0]     i_up,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [DIR_WIDTH-1:0] o_dir_front,
    output logic signed [DIR_WIDTH-1:0] o_dir_right,
    output logic signed [DIR_WIDTH-1:0] o_dir_up,
    output t_status                     o_status
);

    localparam int MAG_W = CMP_W - 1;
    localparam int LEN_W = $clog2(MAG_W + 1);
    // mag, len, shift, square, sum, root, divider, output
    localparam int NST   = 5 + ROOT_W + DIR_WIDTH + 2;
    localparam logic [DIR_WIDTH-1:0] SAT = {1'b0, {(DIR_WIDTH-1){1'b1}}};

    t_ctrl               r_ctl [NST];
    logic                adv;
    logic signed [CMP_W-1:0] comp [3];
    logic [MAG_W-1:0]    r_mag1 [3];
    logic [MAG_W-1:0]    r_mag2 [3];
    logic [LEN_W-1:0]    r_len2, n_len;
    logic [MAG_W-1:0]    mag_or;
    logic [NORM_W-1:0]   r_nm3 [3];
    logic [NORM_W-1:0]   r_nm4 [3];
    logic [2*NORM_W-1:0] r_sq4 [3];
    logic [NORM_W-1:0]   r_nm5 [3];
    logic [SUM_W-1:0]    r_sum5;
    logic [NORM_W-1:0]   r_nmd [ROOT_W][3];
    logic [ROOT_W-1:0]   root;
    logic [DIR_WIDTH-1:0] quot [3];
    logic [DIR_WIDTH-1:0] r_dir [3];
    t_status             zst;

    assign adv   = !r_ctl[NST-1].valid || !i_stall;
    assign o_pop = adv && i_valid;

    assign comp[0] = i_front;
    assign comp[1] = i_right;
    assign comp[2] = i_up;

    assign mag_or = r_mag1[0] | r_mag1[1] | r_mag1[2];
    assign zst    = (r_ctl[0].status == ST_OK && mag_or == '0) ? ST_ZERO : r_ctl[0].status;

    always_comb begin
        n_len = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (mag_or[i]) n_len = LEN_W'(i + 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NST; k++) r_ctl[k] <= '0;
        end else if (adv) begin
            r_ctl[0] <= '{valid: i_valid, status: i_status,
                          neg: {i_up[CMP_W-1], i_right[CMP_W-1], i_front[CMP_W-1]}};
            r_ctl[1] <= '{valid: r_ctl[0].valid, status: zst, neg: r_ctl[0].neg};
            for (int k = 2; k < NST; k++) r_ctl[k] <= r_ctl[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r_mag1[i] <= comp[i][CMP_W-1] ? MAG_W'(-comp[i]) : MAG_W'(comp[i]);
                r_mag2[i] <= r_mag1[i];
                // common shift puts the largest magnitude at bit 30
                r_nm3[i]  <= NORM_W'(({r_mag2[i], {NORM_W{1'b0}}}) >> r_len2);
                r_nm4[i]  <= r_nm3[i];
                r_sq4[i]  <= r_nm3[i] * r_nm3[i];
                r_nm5[i]  <= r_nm4[i];
                r_nmd[0][i] <= r_nm5[i];
                for (int k = 1; k < ROOT_W; k++) r_nmd[k][i] <= r_nmd[k-1][i];
            end
            r_len2 <= n_len;
            r_sum5 <= SUM_W'(r_sq4[0]) + SUM_W'(r_sq4[1]) + SUM_W'(r_sq4[2]);
        end
    end

    rpud_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_sum  (r_sum5),
        .o_root (root)
    );

    for (genvar i = 0; i < 3; i++) begin : g_div
        rpud_div #(.DIR_WIDTH(DIR_WIDTH)) u_div (
            .i_clk  (i_clk),
            .i_en   (adv),
            .i_mag  (r_nmd[ROOT_W-1][i]),
            .i_root (root),
            .o_quot (quot[i])
        );

        always_ff @(posedge i_clk) begin
            if (adv) begin
                if (r_ctl[NST-2].status != ST_OK) begin
                    r_dir[i] <= '0;
                end else if (quot[i] > SAT) begin
                    r_dir[i] <= r_ctl[NST-2].neg[i] ? -SAT : SAT;
                end else begin
                    r_dir[i] <= r_ctl[NST-2].neg[i] ? -quot[i] : quot[i];
                end
            end
        end
    end

    assign o_valid     = r_ctl[NST-1].valid;
    assign o_status    = r_ctl[NST-1].status;
    assign o_dir_front = r_dir[0];
    assign o_dir_right = r_dir[1];
    assign o_dir_up    = r_dir[2];

endmodule

// ===== hw/rtl/room_position_to_unit_direction.sv =====
// Channel   Signals                                      Direction
// config    i_cfg_we, i_cfg_idx, i_cfg_data              in, write only
// input     i_in_valid / o_in_stall, i_pos_*, flags      in
// output    o_out_valid / i_out_stall, o_dir_*, o_status out
//
// One transfer per cycle in each direction, sustained while no output stall.
// Items pass through the front register, the two-entry queue, then the back
// pipeline, whose depth is set mostly by the 32-stage square root and the
// dividers.
// Reset is synchronous, active low; configuration returns to its defaults.
// An output stall while the output is valid freezes the back pipeline; the
// queue lets the front keep taking items until it fills.
module room_position_to_unit_direction
    import rpud_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int DIR_WIDTH   = DIR_WIDTH_DEF,
    parameter int CFG_W       = (COORD_WIDTH > ROOM_W) ? COORD_WIDTH : ROOM_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [CFG_W-1:0]              i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [COORD_WIDTH-1:0] i_pos_x,
    input  logic signed [COORD_WIDTH-1:0] i_pos_y,
    input  logic signed [COORD_WIDTH-1:0] i_pos_z,
    input  logic [1:0]                    i_coordinate_kind,
    input  logic                          i_cartesian_known,
    input  logic                          i_cartesian_flag,
    input  logic                          i_screen_anchored,
    input  logic                          i_distance_infinite,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [DIR_WIDTH-1:0]   o_dir_front,
    output logic signed [DIR_WIDTH-1:0]   o_dir_right,
    output logic signed [DIR_WIDTH-1:0]   o_dir_up,
    output logic [2:0]                    o_status
);

    localparam int CMP_W = COORD_WIDTH + 18;
    localparam int Q_W   = 3 + 3 * CMP_W;

    logic                    f_valid, q_full, q_valid, q_pop;
    t_status                 f_status;
    logic signed [CMP_W-1:0] f_front, f_right, f_up;
    logic [Q_W-1:0]          q_data;

    rpud_front #(.COORD_WIDTH(COORD_WIDTH), .CFG_W(CFG_W), .CMP_W(CMP_W)) u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_valid             (i_in_valid),
        .o_stall             (o_in_stall),
        .i_pos_x             (i_pos_x),
        .i_pos_y             (i_pos_y),
        .i_pos_z             (i_pos_z),
        .i_coordinate_kind   (i_coordinate_kind),
        .i_cartesian_known   (i_cartesian_known),
        .i_cartesian_flag    (i_cartesian_flag),
        .i_screen_anchored   (i_screen_anchored),
        .i_distance_infinite (i_distance_infinite),
        .o_valid             (f_valid),
        .i_full              (q_full),
        .o_status            (f_status),
        .o_front             (f_front),
        .o_right             (f_right),
        .o_up                (f_up)
    );

    rpud_fifo #(.WIDTH(Q_W)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  ({f_status, f_front, f_right, f_up}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    rpud_back #(.COORD_WIDTH(COORD_WIDTH), .DIR_WIDTH(DIR_WIDTH), .CMP_W(CMP_W)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .o_pop       (q_pop),
        .i_status    (q_data[Q_W-1 -: 3]),
        .i_front     ($signed(q_data[3*CMP_W-1 -: CMP_W])),
        .i_right     ($signed(q_data[2*CMP_W-1 -: CMP_W])),
        .i_up        ($signed(q_data[CMP_W-1:0])),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_dir_front (o_dir_front),
        .o_dir_right (o_dir_right),
        .o_dir_up    (o_dir_up),
        .o_status    (o_status)
    );

endmodule
